>>> hdl/smac_pkg.sv
// Package: shared widths, register codes and pipeline types of the crossover signal block.
`default_nettype none

package smac_pkg;

  // Ring geometry
  localparam int MaxWindow = 2048;
  localparam int PtrW      = $clog2(MaxWindow);

  // Field and state widths
  localparam int PriceW = 32;
  localparam int InstW  = 8;
  localparam int LenW   = 12;
  localparam int WarmW  = 16;
  localparam int TotW   = 43;
  localparam int ProdW  = TotW + LenW;

  // Output queue
  localparam int FifoDepth = 8;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Configuration port
  localparam int DataW = 32;
  localparam int AddrW = 4;

  // Register reset values
  localparam logic [LenW-1:0]  ShortLenRst = LenW'(600);
  localparam logic [LenW-1:0]  LongLenRst  = LenW'(1200);
  localparam logic [WarmW-1:0] WarmupRst   = WarmW'(1200);

  // Register index codes (byte address / 4)
  typedef enum logic [1:0] {
    RegShortLen = 2'd0,
    RegLongLen  = 2'd1,
    RegWarmup   = 2'd2
  } smac_reg_e;

  // Order side codes
  localparam logic SideBuy  = 1'b0;
  localparam logic SideSell = 1'b1;

  // Item info carried toward the compare stage
  typedef struct packed {
    logic [InstW-1:0] inst;
    logic [LenW-1:0]  sh_fill;
    logic [LenW-1:0]  lg_fill;
    logic             emit_ok;
  } smac_cmp_t;

  // Item info in the sum-update stage
  typedef struct packed {
    logic [PriceW-1:0] price;
    logic              sh_evict;
    logic              lg_evict;
    smac_cmp_t         cmp;
  } smac_trade_t;

  // Queued order
  typedef struct packed {
    logic             side;
    logic [InstW-1:0] inst;
  } smac_order_t;

  // Clamp a window length into 1..MaxWindow
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] len);
    logic [LenW-1:0] r;
    r = len;
    if (len == '0) r = LenW'(1);
    else if (len > LenW'(MaxWindow)) r = LenW'(MaxWindow);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/smac_if.sv
// Interfaces: trade input channel and order output channel.
`default_nettype none

interface smac_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] price;
  logic [7:0]  instrument_id;

  modport source (output valid, output price, output instrument_id, input ready);
  modport sink   (input valid, input price, input instrument_id, output ready);
endinterface

interface smac_out_if;
  logic       valid;
  logic       ready;
  logic       side;
  logic [7:0] order_instrument;

  modport source (output valid, output side, output order_instrument, input ready);
  modport sink   (input valid, input side, input order_instrument, output ready);
endinterface

`default_nettype wire

>>> hdl/sma_crossover_signal.sv
// Top level: dual moving-average crossover signal generator with ring memories.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+------------------------------------
//   in_ch    | in  | valid / ready  | price[31:0], instrument_id[7:0]
//   out_ch   | out | valid / ready  | side, order_instrument[7:0]
//   apb      | in  | psel / penable | paddr[3:0], pwdata[31:0], prdata[31:0]
//
// One item is accepted per cycle while in_ch.ready is high; each window ring takes one
// read and one write per item. An order passes through the b, c and d stage registers
// and an eight-entry output queue before it is offered.
// in_ch.ready drops only when the queue plus items in flight would fill it.
// Reset clears sums, fills, pointers, trade count and position; ring contents are
// left as they are and are never used before written.
`default_nettype none

module sma_crossover_signal (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  smac_in_if.sink                         in_ch,
  smac_out_if.source                      out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [smac_pkg::AddrW-1:0] paddr,
  input  wire logic [smac_pkg::DataW-1:0] pwdata,
  output      logic [smac_pkg::DataW-1:0] prdata,
  output      logic                       pready
);
  import smac_pkg::*;

  // Configuration registers
  logic [LenW-1:0]  short_len_q, long_len_q;
  logic [WarmW-1:0] warmup_q;

  // Window state
  logic [PriceW-1:0] short_ring [MaxWindow];
  logic [PriceW-1:0] long_ring  [MaxWindow];
  logic [PtrW-1:0]   sh_wptr_q, lg_wptr_q;
  logic [LenW-1:0]   sh_fill_q, lg_fill_q, sh_fill_d, lg_fill_d;
  logic [TotW-1:0]   sh_total_q, lg_total_q;
  logic [WarmW-1:0]  trade_cnt_q, trade_cnt_d;
  logic              in_short_q;

  // Pipeline
  logic              acc;
  logic              sh_evict, lg_evict;
  logic [PtrW-1:0]   sh_raddr, lg_raddr;
  logic [PriceW-1:0] sh_rd_q, lg_rd_q;
  logic              b_vld_q, c_vld_q, d_vld_q;
  smac_trade_t       b_q, b_d;
  smac_cmp_t         c_q;
  logic [ProdW-1:0]  lp_q, sp_q;
  logic [InstW-1:0]  d_inst_q;
  logic              d_emit_q;

  // Output queue
  smac_order_t         fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] fifo_wp_q, fifo_rp_q;
  logic [FifoCntW-1:0] fifo_cnt_q;
  logic [FifoCntW:0]   occupancy;
  logic                push, pop, go_sell, go_buy;

  // Configuration port: always ready, write on access phase
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_len_q <= ShortLenRst;
      long_len_q  <= LongLenRst;
      warmup_q    <= WarmupRst;
    end else if (psel && penable && pwrite) begin
      case (smac_reg_e'(paddr[3:2]))
        RegShortLen: short_len_q <= pwdata[LenW-1:0];
        RegLongLen:  long_len_q  <= pwdata[LenW-1:0];
        RegWarmup:   warmup_q    <= pwdata[WarmW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (smac_reg_e'(paddr[3:2]))
      RegShortLen: prdata = DataW'(short_len_q);
      RegLongLen:  prdata = DataW'(long_len_q);
      RegWarmup:   prdata = DataW'(warmup_q);
      default:     prdata = '0;
    endcase
  end

  // Accept while the queue can hold every item in flight
  assign occupancy = (FifoCntW+1)'(fifo_cnt_q) + (FifoCntW+1)'(b_vld_q)
                   + (FifoCntW+1)'(c_vld_q) + (FifoCntW+1)'(d_vld_q);
  assign in_ch.ready = occupancy < (FifoCntW+1)'(FifoDepth);
  assign acc = in_ch.valid && in_ch.ready;

  // Push stage: decide eviction, address the oldest slot, advance fill and count
  always_comb begin
    sh_evict    = sh_fill_q >= eff_len(short_len_q);
    lg_evict    = lg_fill_q >= eff_len(long_len_q);
    sh_raddr    = sh_wptr_q - sh_fill_q[PtrW-1:0];
    lg_raddr    = lg_wptr_q - lg_fill_q[PtrW-1:0];
    sh_fill_d   = sh_evict ? sh_fill_q : sh_fill_q + LenW'(1);
    lg_fill_d   = lg_evict ? lg_fill_q : lg_fill_q + LenW'(1);
    trade_cnt_d = (trade_cnt_q == '1) ? trade_cnt_q : trade_cnt_q + WarmW'(1);
    b_d.price        = in_ch.price;
    b_d.sh_evict     = sh_evict;
    b_d.lg_evict     = lg_evict;
    b_d.cmp.inst     = in_ch.instrument_id;
    b_d.cmp.sh_fill  = sh_fill_d;
    b_d.cmp.lg_fill  = lg_fill_d;
    b_d.cmp.emit_ok  = trade_cnt_d >= warmup_q;
  end

  // Rings: read the oldest entry before overwriting the write slot
  always_ff @(posedge clk_i) begin
    if (acc) begin
      sh_rd_q <= short_ring[sh_raddr];
      lg_rd_q <= long_ring[lg_raddr];
      short_ring[sh_wptr_q] <= in_ch.price;
      long_ring[lg_wptr_q]  <= in_ch.price;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_wptr_q   <= '0;
      lg_wptr_q   <= '0;
      sh_fill_q   <= '0;
      lg_fill_q   <= '0;
      trade_cnt_q <= '0;
    end else if (acc) begin
      sh_wptr_q   <= sh_wptr_q + PtrW'(1);
      lg_wptr_q   <= lg_wptr_q + PtrW'(1);
      sh_fill_q   <= sh_fill_d;
      lg_fill_q   <= lg_fill_d;
      trade_cnt_q <= trade_cnt_d;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      b_vld_q <= acc;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  // Sum stage: drop the evicted entry, add the new price
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_total_q <= '0;
      lg_total_q <= '0;
    end else if (b_vld_q) begin
      sh_total_q <= sh_total_q + TotW'(b_q.price)
                    - (b_q.sh_evict ? TotW'(sh_rd_q) : TotW'(0));
      lg_total_q <= lg_total_q + TotW'(b_q.price)
                    - (b_q.lg_evict ? TotW'(lg_rd_q) : TotW'(0));
    end
  end

  // Payload pipeline registers
  always_ff @(posedge clk_i) begin
    if (acc) b_q <= b_d;
    if (b_vld_q) c_q <= b_q.cmp;
    if (c_vld_q) begin
      lp_q     <= ProdW'(lg_total_q) * ProdW'(c_q.sh_fill);
      sp_q     <= ProdW'(sh_total_q) * ProdW'(c_q.lg_fill);
      d_inst_q <= c_q.inst;
      d_emit_q <= c_q.emit_ok;
    end
  end

  // Compare stage: cross-multiplied means against the position
  assign go_sell = d_vld_q && d_emit_q && (lp_q > sp_q) && !in_short_q;
  assign go_buy  = d_vld_q && d_emit_q && (lp_q < sp_q) && in_short_q;
  assign push    = go_sell || go_buy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_short_q <= 1'b0;
    end else if (push) begin
      in_short_q <= go_sell;
    end
  end

  // Output queue
  assign pop                  = out_ch.valid && out_ch.ready;
  assign out_ch.valid         = fifo_cnt_q != '0;
  assign out_ch.side          = fifo_q[fifo_rp_q].side;
  assign out_ch.order_instrument = fifo_q[fifo_rp_q].inst;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[fifo_wp_q].side <= go_sell ? SideSell : SideBuy;
      fifo_q[fifo_wp_q].inst <= d_inst_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wp_q  <= '0;
      fifo_rp_q  <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) fifo_wp_q <= fifo_wp_q + FifoPtrW'(1);
      if (pop)  fifo_rp_q <= fifo_rp_q + FifoPtrW'(1);
      if (push && !pop) fifo_cnt_q <= fifo_cnt_q + FifoCntW'(1);
      else if (pop && !push) fifo_cnt_q <= fifo_cnt_q - FifoCntW'(1);
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_sma_crossover_signal.sv
`timescale 1ns / 1ps
// Testbench: trade stream into the crossover signal block, orders checked against a predictor.

module tb_sma_crossover_signal;
  import smac_pkg::*;

  localparam int DrainCycles = 16;
  localparam int RandItems   = 620;
  localparam int HoldCycles  = 400;
  localparam int WinShort    = 0;
  localparam int WinLong     = 1;

  typedef enum logic {RowTrade, RowWrite} row_kind_e;
  typedef enum logic {ExpModel, ExpNone} exp_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    smac_reg_e   reg_sel;
    logic [31:0] data;
    logic [7:0]  inst;
    exp_kind_e   exp;
  } stim_row_t;

  // Directed rows: trades carry price and instrument, writes carry the register value
  localparam int NumRows = 24;
  localparam stim_row_t DirRows [NumRows] = '{
    // after reset the warm-up of 1200 trades blocks any order
    '{RowTrade, RegShortLen, 32'hFFFF_FFFF, 8'hA5, ExpNone},
    '{RowTrade, RegShortLen, 32'h0000_0000, 8'h5A, ExpNone},
    // zero short length, long length above the ring size, no warm-up
    '{RowWrite, RegShortLen, 32'd0,         8'h00, ExpModel},
    '{RowWrite, RegLongLen,  32'd4095,      8'h00, ExpModel},
    '{RowWrite, RegWarmup,   32'd0,         8'h00, ExpModel},
    '{RowTrade, RegShortLen, 32'hFFFF_FFFF, 8'h01, ExpModel},
    '{RowTrade, RegShortLen, 32'hFFFF_FFFF, 8'h02, ExpModel},
    '{RowTrade, RegShortLen, 32'h0000_0000, 8'h03, ExpModel},
    '{RowTrade, RegShortLen, 32'h0000_0000, 8'h04, ExpModel},
    '{RowTrade, RegShortLen, 32'hFFFF_FFFF, 8'h05, ExpModel},
    '{RowTrade, RegShortLen, 32'h0001_0000, 8'h06, ExpModel},
    // shrink the long window at run time
    '{RowWrite, RegLongLen,  32'd3,         8'h00, ExpModel},
    '{RowTrade, RegShortLen, 32'h8000_0000, 8'h07, ExpModel},
    '{RowTrade, RegShortLen, 32'h0000_0000, 8'h08, ExpModel},
    '{RowTrade, RegShortLen, 32'hFFFF_FFFF, 8'h09, ExpModel},
    '{RowTrade, RegShortLen, 32'h0000_0001, 8'hFF, ExpModel},
    // full-size short window, unit long window
    '{RowWrite, RegShortLen, 32'd2048,      8'h00, ExpModel},
    '{RowWrite, RegLongLen,  32'd1,         8'h00, ExpModel},
    '{RowTrade, RegShortLen, 32'h1234_5678, 8'h0B, ExpModel},
    '{RowTrade, RegShortLen, 32'h0000_0000, 8'h00, ExpModel},
    '{RowTrade, RegShortLen, 32'hFFFF_FFFF, 8'h0D, ExpModel},
    '{RowWrite, RegShortLen, 32'd1,         8'h00, ExpModel},
    '{RowTrade, RegShortLen, 32'hDEAD_BEEF, 8'h0E, ExpModel},
    '{RowTrade, RegShortLen, 32'h0000_0000, 8'hF0, ExpModel}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  smac_in_if  trade_ch ();
  smac_out_if order_ch ();

  sma_crossover_signal i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (trade_ch),
    .out_ch  (order_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: one ring, sum, fill and write pointer per window
  logic [PriceW-1:0] ring_mem [2][MaxWindow];
  logic [TotW-1:0]   win_sum  [2];
  logic [LenW-1:0]   win_fill [2];
  logic [PtrW-1:0]   win_wptr [2];
  logic [WarmW-1:0]  trades_seen;
  logic              pos_short;
  logic [LenW-1:0]   cfg_short;
  logic [LenW-1:0]   cfg_long;
  logic [WarmW-1:0]  cfg_warmup;

  smac_order_t pending_orders [$];
  int          err_count   = 0;
  int          trades_sent = 0;
  int          src_gap_max = 0;
  int          snk_gap_max = 0;
  int          sink_hold   = 0;
  logic [31:0] walk_px;
  logic [31:0] walk_step;
  logic        zz_high;

  function automatic int draw_gap(input int max_gap);
    return (max_gap == 0) ? 0 : int'($urandom_range(0, max_gap));
  endfunction

  // Map a programmed length onto the window size actually used
  function automatic logic [LenW-1:0] window_span(input logic [LenW-1:0] len);
    if (len == '0) return LenW'(1);
    if (len > LenW'(MaxWindow)) return LenW'(MaxWindow);
    return len;
  endfunction

  // Drop the oldest entry once the window is full, then add the new price
  task automatic window_push(input int w, input logic [LenW-1:0] len,
                             input logic [PriceW-1:0] price);
    logic [LenW-1:0] span;
    logic [PtrW-1:0] slot;
    span = window_span(len);
    if (win_fill[w] >= span) begin
      slot = win_wptr[w] - win_fill[w][PtrW-1:0];
      win_sum[w] = win_sum[w] - TotW'(ring_mem[w][slot]);
    end else begin
      win_fill[w] = win_fill[w] + LenW'(1);
    end
    ring_mem[w][win_wptr[w]] = price;
    win_sum[w] = win_sum[w] + TotW'(price);
    win_wptr[w] = win_wptr[w] + PtrW'(1);
  endtask

  // Advance both windows and decide whether this trade flips the position
  task automatic predict_trade(input logic [PriceW-1:0] price, input logic [InstW-1:0] inst,
                               output logic emit, output smac_order_t ord);
    logic [63:0] long_side;
    logic [63:0] short_side;
    window_push(WinShort, cfg_short, price);
    window_push(WinLong, cfg_long, price);
    if (trades_seen != '1) trades_seen = trades_seen + WarmW'(1);
    emit = 1'b0;
    ord.side = SideBuy;
    ord.inst = inst;
    if (trades_seen >= cfg_warmup) begin
      long_side  = 64'(win_sum[WinLong]) * 64'(win_fill[WinShort]);
      short_side = 64'(win_sum[WinShort]) * 64'(win_fill[WinLong]);
      if (long_side > short_side && !pos_short) begin
        pos_short = 1'b1;
        emit = 1'b1;
        ord.side = SideSell;
      end else if (long_side < short_side && pos_short) begin
        pos_short = 1'b0;
        emit = 1'b1;
        ord.side = SideBuy;
      end
    end
  endtask

  // Random walk with drift changes, plus extremes and noise
  function automatic logic [31:0] next_price();
    case ($urandom_range(0, 31))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom();
      default: begin
        if ($urandom_range(0, 7) == 0) begin
          walk_step = 32'($urandom_range(0, 32'h0100_0000));
          if ($urandom_range(0, 1) == 1) walk_step = -walk_step;
        end
        walk_px = walk_px + walk_step + 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        return walk_px;
      end
    endcase
  endfunction

  function automatic logic [LenW-1:0] pick_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LenW'(MaxWindow);
      2: return LenW'($urandom_range(MaxWindow + 1, 4095));
      3: return LenW'($urandom());
      default: return LenW'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [WarmW-1:0] pick_warmup();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return WarmW'($urandom());
      default: return WarmW'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      default: return 15;
    endcase
  endfunction

  // One APB transfer; leaves psel high so a following transfer can start at once
  task automatic apb_xfer(input logic wr, input smac_reg_e idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
  endtask

  // Write a register with junk in the unused bits, read it back, update the predictor
  task automatic write_reg(input smac_reg_e idx, input logic [31:0] value);
    logic [31:0] keep;
    logic [31:0] rdata;
    keep = (idx == RegWarmup) ? 32'h0000_FFFF : 32'h0000_0FFF;
    apb_xfer(1'b1, idx, ($urandom() & ~keep) | (value & keep), rdata);
    apb_xfer(1'b0, idx, $urandom(), rdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegShortLen: cfg_short  = value[LenW-1:0];
      RegLongLen:  cfg_long   = value[LenW-1:0];
      RegWarmup:   cfg_warmup = value[WarmW-1:0];
      default: ;
    endcase
    if (rdata !== (value & keep)) begin
      $display("%0t: register %0d readback expected %0h got %0h",
               $time, idx, value & keep, rdata);
      err_count++;
    end
  endtask

  // Offer one item after a random gap, then predict once it is taken
  task automatic send_trade(input logic [31:0] price, input logic [7:0] inst,
                            input exp_kind_e kind);
    int          gap;
    logic        emit;
    smac_order_t ord;
    gap = draw_gap(src_gap_max);
    if (gap > 0) begin
      trade_ch.valid         <= 1'b0;
      trade_ch.price         <= $urandom();
      trade_ch.instrument_id <= 8'($urandom());
      repeat (gap) @(posedge clk_i);
    end
    trade_ch.valid         <= 1'b1;
    trade_ch.price         <= price;
    trade_ch.instrument_id <= inst;
    do @(posedge clk_i); while (trade_ch.ready !== 1'b1);
    trades_sent++;
    predict_trade(price, inst, emit, ord);
    if (emit && kind == ExpModel) pending_orders.push_back(ord);
  endtask

  // Hold the input idle until every expected order is out and the pipe is empty
  task automatic settle();
    trade_ch.valid <= 1'b0;
    while (pending_orders.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Zigzag prices flip the position on nearly every trade
  task automatic run_phase(input int count, input logic zigzag);
    logic [31:0] px;
    repeat (count) begin
      if (zigzag) begin
        zz_high = ~zz_high;
        px = zz_high ? $urandom_range(32'h8000_0000, 32'hFFFF_FFFF)
                     : $urandom_range(32'h0000_0000, 32'h7FFF_FFFF);
      end else begin
        px = next_price();
      end
      send_trade(px, 8'($urandom()), ExpModel);
    end
  endtask

  task automatic write_all(input logic [LenW-1:0] s_len, input logic [LenW-1:0] l_len,
                           input logic [WarmW-1:0] warm);
    write_reg(RegShortLen, 32'(s_len));
    write_reg(RegLongLen, 32'(l_len));
    write_reg(RegWarmup, 32'(warm));
  endtask

  // Order sink: random stalls, one long hold-off on request, check each order
  initial begin : order_sink
    int          gap;
    smac_order_t want;
    order_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold > 0) begin
        gap = sink_hold;
        sink_hold = 0;
      end else begin
        gap = draw_gap(snk_gap_max);
      end
      if (gap > 0) begin
        order_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      order_ch.ready <= 1'b1;
      do @(posedge clk_i); while (order_ch.valid !== 1'b1);
      if (pending_orders.size() == 0) begin
        $display("%0t: unexpected order, expected none, got side %0b instrument %0h",
                 $time, order_ch.side, order_ch.order_instrument);
        err_count++;
      end else begin
        want = pending_orders.pop_front();
        if (order_ch.side !== want.side) begin
          $display("%0t: side expected %0b got %0b", $time, want.side, order_ch.side);
          err_count++;
        end
        if (order_ch.order_instrument !== want.inst) begin
          $display("%0t: instrument expected %0h got %0h",
                   $time, want.inst, order_ch.order_instrument);
          err_count++;
        end
      end
    end
  end

  // Stimulus: directed table, pressure phase, random phases, largest warm-up
  initial begin : stimulus
    rst_ni                 <= 1'b0;
    trade_ch.valid         <= 1'b0;
    trade_ch.price         <= '0;
    trade_ch.instrument_id <= '0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    win_sum     = '{default: '0};
    win_fill    = '{default: '0};
    win_wptr    = '{default: '0};
    trades_seen = '0;
    pos_short   = 1'b0;
    cfg_short   = ShortLenRst;
    cfg_long    = LongLenRst;
    cfg_warmup  = WarmupRst;
    walk_px     = $urandom();
    walk_step   = 32'h0001_0000;
    zz_high     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int r = 0; r < NumRows; r++) begin
      if (DirRows[r].kind == RowWrite) begin
        settle();
        write_reg(DirRows[r].reg_sel, DirRows[r].data);
      end else begin
        send_trade(DirRows[r].data, DirRows[r].inst, DirRows[r].exp);
      end
    end

    // Fill the output queue behind a long receiver hold-off
    settle();
    write_all(LenW'(1), LenW'(2), '0);
    src_gap_max = 0;
    snk_gap_max = 0;
    sink_hold   = HoldCycles;
    run_phase(80, 1'b1);

    // Random settings per phase
    while (trades_sent < RandItems) begin
      settle();
      write_all(pick_len(), pick_len(), pick_warmup());
      src_gap_max = pick_gap();
      snk_gap_max = pick_gap();
      run_phase($urandom_range(40, 140), $urandom_range(0, 7) == 0);
    end

    // Keep trading with new windows under the largest warm-up
    settle();
    write_all(pick_len(), pick_len(), '1);
    src_gap_max = 15;
    snk_gap_max = 15;
    run_phase(150, 1'b0);

    settle();
    if (err_count == 0 && pending_orders.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
hdl/smac_pkg.sv
hdl/smac_if.sv
hdl/sma_crossover_signal.sv
dv/tb_sma_crossover_signal.sv
